>>> rtl/lkv_pkg.sv
// Shared constants and types for the LRU key-value cache.
// No dependencies; imported by lru_key_value_cache.
package lkv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int CMP_W       = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int ADDR_W      = 3;
  localparam int APB_W       = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
  localparam logic [ADDR_W-1:0] ADDR_CAP  = ADDR_W'(0);
  localparam logic [VAL_W-1:0]  MISS_VAL  = '1;
  localparam logic              REQ_GET   = 1'b0;
  localparam logic              REQ_PUT   = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] val_t;

endpackage

>>> rtl/lru_key_value_cache.sv
// Fully associative key-value cache with LRU replacement, 16 register entries.
// Path: an accepted input word goes to the input reg, then its result goes to the result reg.
// Throughput: one word per cycle while out_tready allows; key compare, slot pick and rank update run in the same cycle.
// Reset (rst_n, sync): all entries invalid, ranks and occupancy zero, capacity 16.
// Depends on lkv_pkg.
module lru_key_value_cache
  import lkv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [63:0]       in_tdata,   // [31:0] key, [63:32] put_value
  input  logic              in_tuser,   // [0] req_type
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // [31:0] read_value
  output logic              out_tuser,  // [0] found
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [APB_W-1:0]  cfg_pwdata,
  output logic [APB_W-1:0]  cfg_prdata,
  output logic              cfg_pready
);

  logic [CAP_W-1:0] cap_r;

  logic             in_v_r;
  logic             in_put_r;
  key_t             in_key_r;
  val_t             in_val_r;

  logic             out_v_r;
  logic             out_found_r;
  val_t             out_val_r;

  key_t             keys_r  [MAX_ENTRIES];
  val_t             vals_r  [MAX_ENTRIES];
  logic             valid_r [MAX_ENTRIES];
  idx_t             rank_r  [MAX_ENTRIES];
  cnt_t             occ_r;

  logic             valid_nxt [MAX_ENTRIES];
  idx_t             rank_nxt  [MAX_ENTRIES];
  cnt_t             occ_nxt;

  logic             adv;
  logic             go;
  logic             hit;
  idx_t             hit_idx;
  idx_t             free_idx;
  idx_t             vic_idx;
  idx_t             slot;
  logic             room;
  logic             insert;
  logic             touch;
  cnt_t             old_rank;
  cnt_t             last_rank;
  logic [CMP_W-1:0] cap_eff;
  logic [CMP_W-1:0] cap_ext;

  assign adv       = !out_v_r || out_tready;
  assign go        = in_v_r && adv;
  assign in_tready = !in_v_r || adv;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_found_r;

  assign cfg_pready  = 1'b1;
  assign cfg_prdata  = (cfg_paddr == ADDR_CAP) ? APB_W'(cap_r) : '0;

  // effective capacity: clamp to 1 .. MAX_ENTRIES
  assign cap_ext = CMP_W'(cap_r);
  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      cap_eff = CMP_W'(MAX_ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign room      = CMP_W'(occ_r) < cap_eff;
  assign last_rank = occ_r - CNT_W'(1);

  // lookup, free slot and victim search
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    vic_idx  = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && keys_r[i] == in_key_r) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
      if (valid_r[i] && rank_r[i] == last_rank[IDX_W-1:0]) begin
        vic_idx = IDX_W'(i);
      end
    end
  end

  assign insert = in_put_r && !hit && room;
  assign touch  = hit || in_put_r;
  assign slot   = hit ? hit_idx : (room ? free_idx : vic_idx);

  always_comb begin
    if (hit) begin
      old_rank = CNT_W'(rank_r[hit_idx]);
    end else if (room) begin
      old_rank = occ_r;
    end else begin
      old_rank = last_rank;
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      valid_nxt[i] = valid_r[i];
      rank_nxt[i]  = rank_r[i];
    end
    if (go && touch) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (valid_r[i] && CNT_W'(rank_r[i]) < old_rank) begin
          rank_nxt[i] = rank_r[i] + IDX_W'(1);
        end
        if (idx_t'(i) == slot) begin
          rank_nxt[i]  = '0;
          valid_nxt[i] = 1'b1;
        end
      end
      if (insert) begin
        occ_nxt = occ_r + CNT_W'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      occ_r   <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= '0;
      end
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == ADDR_CAP) begin
        cap_r <= cfg_pwdata[CAP_W-1:0];
      end
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (adv) begin
        out_v_r <= in_v_r;
      end
      occ_r <= occ_nxt;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        valid_r[i] <= valid_nxt[i];
        rank_r[i]  <= rank_nxt[i];
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_put_r <= in_tuser;
      in_key_r <= in_tdata[KEY_W-1:0];
      in_val_r <= in_tdata[KEY_W+VAL_W-1:KEY_W];
    end
    if (go) begin
      out_found_r <= hit;
      if (in_put_r == REQ_PUT) begin
        out_val_r <= '0;
      end else if (hit) begin
        out_val_r <= vals_r[hit_idx];
      end else begin
        out_val_r <= MISS_VAL;
      end
      if (in_put_r == REQ_PUT) begin
        keys_r[slot] <= in_key_r;
        vals_r[slot] <= in_val_r;
      end
    end
  end

`ifndef NO_ASSERTIONS
  logic [CNT_W-1:0] valid_cnt;
  always_comb begin
    valid_cnt = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      valid_cnt = valid_cnt + CNT_W'(valid_r[i]);
    end
  end

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    valid_cnt == occ_r)
    else $error("occupancy count disagrees with valid entries");

  a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(MAX_ENTRIES))
    else $error("occupancy above entry count");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    go && insert |=> occ_r == $past(occ_r) + CNT_W'(1))
    else $error("put miss with room did not add an entry");

  a_get_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    go && in_put_r == REQ_GET && !hit |=> out_v_r && !out_found_r && out_val_r == MISS_VAL)
    else $error("get miss result wrong");

  a_no_touch_on_get_miss: assert property (@(posedge clk) disable iff (!rst_n)
    go && in_put_r == REQ_GET && !hit |=> $stable(occ_r))
    else $error("get miss changed occupancy");
`endif

endmodule

>>> dv/tb_lru_key_value_cache.sv
// Self-checking testbench for lru_key_value_cache: get/put words over the stream ports,
// capacity over APB, results checked against an in-bench LRU cache predictor.
// Depends on lkv_pkg and the lru_key_value_cache RTL.
`timescale 1ns / 1ps

module tb_lru_key_value_cache;
  import lkv_pkg::*;

  localparam int LONG_HOLD  = 300;
  localparam int IDLE_LIMIT = 4000;
  localparam int POOL_SIZE  = 40;
  localparam int MAX_PRINTS = 50;

  typedef struct packed {
    logic req;
    key_t key;
    val_t value;
  } req_word_t;

  typedef struct packed {
    logic found;
    val_t value;
  } lookup_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [63:0]       in_tdata = '0;     // [31:0] key, [63:32] put_value
  logic              in_tuser = 1'b0;   // [0] req_type
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;         // [31:0] read_value
  logic              out_tuser;         // [0] found
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [APB_W-1:0]  cfg_pwdata = '0;
  logic [APB_W-1:0]  cfg_prdata;
  logic              cfg_pready;

  lru_key_value_cache dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  key_t             ent_key [MAX_ENTRIES];
  val_t             ent_val [MAX_ENTRIES];
  logic             ent_vld [MAX_ENTRIES];
  int               ent_rank[MAX_ENTRIES];
  int               occupied = 0;
  logic [CAP_W-1:0] cap_reg = CAP_RESET;

  req_word_t pending_words[$];
  lookup_t   expected_lookups[$];
  key_t      key_pool[POOL_SIZE];
  int        pool_n = 20;

  int n_errors = 0, n_sent = 0, n_checked = 0;
  int n_hits = 0, n_misses = 0, n_evictions = 0, n_settings = 0;

  function automatic int eff_capacity();
    if (cap_reg == 0) return 1;
    if (cap_reg > MAX_ENTRIES) return MAX_ENTRIES;
    return int'(cap_reg);
  endfunction

  task automatic promote_entry(input int s);
    int old_rank;
    old_rank = ent_rank[s];
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (i != s && ent_vld[i] && ent_rank[i] < old_rank) ent_rank[i]++;
    ent_rank[s] = 0;
  endtask

  task automatic cache_access(input logic req, input key_t k, input val_t v,
                              output lookup_t res);
    int slot;
    int worst;
    slot = -1;
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (slot < 0 && ent_vld[i] && ent_key[i] == k) slot = i;
    res.found = (slot >= 0);
    res.value = '0;
    if (req == REQ_GET) begin
      if (res.found) begin
        res.value = ent_val[slot];
        promote_entry(slot);
        n_hits++;
      end else begin
        res.value = MISS_VAL;
        n_misses++;
      end
    end else if (res.found) begin
      ent_val[slot] = v;
      promote_entry(slot);
      n_hits++;
    end else begin
      n_misses++;
      if (occupied < eff_capacity()) begin
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (slot < 0 && !ent_vld[i]) slot = i;
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (ent_vld[i]) ent_rank[i]++;
        ent_vld[slot]  = 1'b1;
        ent_rank[slot] = 0;
        occupied++;
      end else begin
        worst = -1;
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (ent_vld[i] && ent_rank[i] > worst) begin
            worst = ent_rank[i];
            slot  = i;
          end
        promote_entry(slot);
        n_evictions++;
      end
      ent_key[slot] = k;
      ent_val[slot] = v;
    end
  endtask

  // driver: bursts of random length, random gaps
  logic    drv_valid_next;
  int      burst_left = 0;
  int      gap_left = 0;
  lookup_t drv_lookup;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      drv_valid_next = in_tvalid;
      if (in_tvalid && in_tready) begin
        cache_access(in_tuser, in_tdata[31:0], in_tdata[63:32], drv_lookup);
        expected_lookups.push_back(drv_lookup);
        n_sent++;
        drv_valid_next = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (!drv_valid_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          req_word_t w;
          w = pending_words.pop_front();
          in_tuser <= w.req;
          in_tdata <= {w.value, w.key};
          drv_valid_next = 1'b1;
        end
      end
      in_tvalid <= drv_valid_next;
    end
  end

  // receiver: stall pattern switches mode at random, plus requested long hold-offs
  int       rx_mode = 0;
  int       rx_mode_left = 0;
  int       rx_hold_left = 0;
  int       rx_hold_requests = 0;
  int       rx_hold_served = 0;
  bit [2:0] rx_phase = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (rx_hold_left == 0 && rx_hold_served != rx_hold_requests) begin
        rx_hold_served++;
        rx_hold_left = LONG_HOLD;
      end
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 120);
      end else begin
        rx_mode_left--;
      end
      rx_phase++;
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 5) != 0);
          default: out_tready <= (rx_phase < 3'd5);
        endcase
      end
    end
  end

  // monitor
  lookup_t want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_lookups.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_PRINTS)
          $display("%0t: unexpected result word found=%0b value=%h", $time, out_tuser,
                   out_tdata);
      end else begin
        want = expected_lookups.pop_front();
        n_checked++;
        if (out_tuser !== want.found) begin
          n_errors++;
          if (n_errors <= MAX_PRINTS)
            $display("%0t: found mismatch, expected %0b actual %0b", $time, want.found,
                     out_tuser);
        end
        if (out_tdata !== want.value) begin
          n_errors++;
          if (n_errors <= MAX_PRINTS)
            $display("%0t: read_value mismatch, expected %h actual %h", $time, want.value,
                     out_tdata);
        end
      end
    end
  end

  // watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                 IDLE_LIMIT, expected_lookups.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic push_word(input logic req, input key_t k, input val_t v);
    req_word_t w;
    w.req   = req;
    w.key   = k;
    w.value = v;
    pending_words.push_back(w);
  endtask

  task automatic wait_idle();
    while (pending_words.size() > 0 || in_tvalid || expected_lookups.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [APB_W-1:0] word);
    logic [APB_W-1:0] rd;
    wait_idle();
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= ADDR_CAP;
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cap_reg = word[CAP_W-1:0];
    n_settings++;
    @(posedge clk);
    cfg_psel <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd[CAP_W-1:0] !== cap_reg) begin
      n_errors++;
      $display("%0t: capacity readback mismatch, expected %0d actual %0d", $time, cap_reg,
               rd[CAP_W-1:0]);
    end
  endtask

  function automatic val_t pick_value();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int count);
    key_t k;
    pool_n = eff_capacity() + $urandom_range(1, 6);
    repeat ($urandom_range(0, pool_n / 2))
      key_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom;
    repeat (count) begin
      if ($urandom_range(0, 6) == 0) k = $urandom;
      else k = key_pool[$urandom_range(0, pool_n - 1)];
      push_word($urandom_range(0, 1) ? REQ_PUT : REQ_GET, k, pick_value());
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ent_vld[i]  = 1'b0;
      ent_rank[i] = 0;
      ent_key[i]  = '0;
      ent_val[i]  = '0;
    end
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    // odd slots from 5 up differ from the slot below by one bit to exercise the key compare
    for (int i = 4; i < POOL_SIZE; i++)
      key_pool[i] = (i % 2) ? key_pool[i-1] ^ (32'h1 << $urandom_range(0, 31)) : $urandom;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset capacity: extremes, overwrite, stored -1 vs miss
    push_word(REQ_GET, 32'h0000_0000, $urandom);
    push_word(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    push_word(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    push_word(REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    push_word(REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    push_word(REQ_GET, 32'hFFFF_FFFF, $urandom);
    push_word(REQ_GET, 32'h0000_0000, $urandom);
    push_word(REQ_GET, 32'h8000_0000, $urandom);
    push_word(REQ_PUT, 32'h8000_0000, 32'h1234_5678);
    push_word(REQ_GET, 32'h8000_0000, $urandom);
    push_word(REQ_GET, 32'h0000_0001, $urandom);
    push_word(REQ_GET, 32'h7FFF_FFFF, $urandom);
    send_random(100);

    // capacity 2 below occupancy: LRU order
    set_capacity(2);
    push_word(REQ_PUT, 32'h0000_1111, 32'hA5A5_0001);
    push_word(REQ_PUT, 32'h2222_0000, 32'hA5A5_0002);
    push_word(REQ_GET, 32'h0000_1111, $urandom);
    push_word(REQ_PUT, 32'h3333_3333, 32'hA5A5_0003);
    push_word(REQ_GET, 32'h2222_0000, $urandom);
    push_word(REQ_GET, 32'h0000_1111, $urandom);
    push_word(REQ_GET, 32'h3333_3333, $urandom);
    send_random(60);

    // zero acts as one
    set_capacity(0);
    push_word(REQ_PUT, 32'h4444_4444, 32'h5A5A_0004);
    push_word(REQ_GET, 32'h3333_3333, $urandom);
    push_word(REQ_GET, 32'h0000_1111, $urandom);
    push_word(REQ_PUT, 32'h5555_5555, 32'h5A5A_0005);
    push_word(REQ_GET, 32'h4444_4444, $urandom);
    send_random(40);

    set_capacity(31);
    send_random(120);

    // upper bits ignored; long receiver hold-off while the sender keeps going
    set_capacity(32'hFFFF_FFF0);
    send_random(40);
    rx_hold_requests++;
    send_random(160);

    set_capacity(3);
    send_random(120);

    set_capacity(1);
    send_random(50);

    set_capacity({27'($urandom_range(0, 2**27 - 1)), 5'($urandom_range(1, 16))});
    send_random(100);

    set_capacity(16);
    send_random(100);

    wait_idle();
    repeat (8) @(posedge clk);
    if (expected_lookups.size() != 0) begin
      n_errors++;
      $display("%0t: %0d expected results never arrived", $time, expected_lookups.size());
    end
    $display("Sent %0d requests over %0d capacity settings: %0d hits, %0d misses, %0d evictions",
             n_sent, n_settings, n_hits, n_misses, n_evictions);
    $display("Checked %0d result words, %0d errors", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
